/* rtl/aavr_pkg.sv */
// ----------------------------------------------------------------------------
// Axis-angle vector rotation: shared package
// Formats, beat structs and the arctangent table used by the pipeline.
// ----------------------------------------------------------------------------
package aavr_pkg;

  localparam int COMP_BITS         = 16;
  localparam int ANGLE_BITS        = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int TRIG_Q            = 30;
  localparam int QUAT_Q            = 22;
  localparam int P_GUARD           = 6;
  localparam int RSQRT_STEPS       = 5;
  localparam int TRIG_W            = 32;
  localparam int UNIT_W            = 32;
  localparam int RY_W              = 33;
  localparam int NORM_W            = 2 * COMP_BITS;

  localparam logic signed [TRIG_W-1:0] INV_GAIN = TRIG_W'(652032874);
  localparam logic [RY_W-1:0]          Y0_BASE  = RY_W'(64'd2415919104);

  typedef logic signed [COMP_BITS-1:0] comp_t;

  typedef struct packed {
    comp_t                  vec_x;
    comp_t                  vec_y;
    comp_t                  vec_z;
    comp_t                  axis_x;
    comp_t                  axis_y;
    comp_t                  axis_z;
    logic [ANGLE_BITS-1:0]  angle_turn;
  } in_beat_t;

  typedef struct packed {
    comp_t out_x;
    comp_t out_y;
    comp_t out_z;
    logic  zero_axis;
    logic  saturated;
  } out_beat_t;

  typedef struct packed {
    logic [2:0][COMP_BITS-1:0] vec;
    logic [2:0][UNIT_W-1:0]    unit;
    logic [ANGLE_BITS-1:0]     angle;
    logic                      zero;
  } axis_beat_t;

  typedef struct packed {
    logic [2:0][COMP_BITS-1:0] vec;
    logic [2:0][UNIT_W-1:0]    unit;
    logic [TRIG_W-1:0]         cos_v;
    logic [TRIG_W-1:0]         sin_v;
    logic                      zero;
  } trig_beat_t;

  function automatic logic [TRIG_W-1:0] atan_turn(input int idx);
    case (idx)
      0:       return TRIG_W'(536870912);
      1:       return TRIG_W'(316933406);
      2:       return TRIG_W'(167458907);
      3:       return TRIG_W'(85004756);
      4:       return TRIG_W'(42667331);
      5:       return TRIG_W'(21354465);
      6:       return TRIG_W'(10679838);
      7:       return TRIG_W'(5340245);
      8:       return TRIG_W'(2670163);
      9:       return TRIG_W'(1335087);
      10:      return TRIG_W'(667544);
      11:      return TRIG_W'(333772);
      12:      return TRIG_W'(166886);
      13:      return TRIG_W'(83443);
      14:      return TRIG_W'(41722);
      15:      return TRIG_W'(20861);
      16:      return TRIG_W'(10430);
      17:      return TRIG_W'(5215);
      18:      return TRIG_W'(2608);
      19:      return TRIG_W'(1304);
      20:      return TRIG_W'(652);
      21:      return TRIG_W'(326);
      22:      return TRIG_W'(163);
      23:      return TRIG_W'(81);
      24:      return TRIG_W'(41);
      25:      return TRIG_W'(20);
      26:      return TRIG_W'(10);
      27:      return TRIG_W'(5);
      28:      return TRIG_W'(3);
      29:      return TRIG_W'(1);
      30:      return TRIG_W'(1);
      default: return '0;
    endcase
  endfunction

endpackage

/* rtl/aavr_rsqrt.sv */
// ----------------------------------------------------------------------------
// Axis normalizer
// Squares and sums the axis, normalizes it, runs Newton steps for the
// reciprocal square root and scales the axis to a unit vector.
// ----------------------------------------------------------------------------
module aavr_rsqrt import aavr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic       in_valid,
  input  in_beat_t   in_beat,
  output logic       out_valid,
  output axis_beat_t out_beat
);

  localparam int PROD_W = COMP_BITS + RY_W + 1;
  localparam int J_W    = $clog2(COMP_BITS);
  localparam int E_W    = $clog2(COMP_BITS + 1);
  localparam int NEWT0  = 5;
  localparam int UMUL   = NEWT0 + 3 * RSQRT_STEPS;
  localparam int NST    = UMUL + 2;
  localparam logic [RY_W-1:0] THREE = RY_W'(3) << TRIG_Q;

  typedef struct packed {
    logic [2:0][COMP_BITS-1:0] vec;
    logic [2:0][COMP_BITS-1:0] axis;
    logic [ANGLE_BITS-1:0]     angle;
    logic                      zero;
    logic [NORM_W-1:0]         m;
    logic [J_W-1:0]            jsh;
    logic [RY_W-1:0]           y;
    logic [RY_W-1:0]           tmp;
    logic [2:0][PROD_W-1:0]    prod;
  } rsq_st_t;

  rsq_st_t        st_r   [NST];
  rsq_st_t        st_nxt [NST];
  logic [NST-1:0] vld_r;

  always_comb begin
    logic signed [NORM_W-1:0] sqr;
    logic [NORM_W-1:0]        nsum;
    logic [2*RY_W-1:0]        mul;
    logic [RY_W-1:0]          dval;
    logic [NORM_W+1:0]        five_m;
    logic signed [PROD_W-1:0] ayp;
    logic [E_W-1:0]           esh;
    int                       b;
    for (int s = 1; s < NST; s++) st_nxt[s] = st_r[s-1];

    st_nxt[0]       = '0;
    st_nxt[0].vec   = {in_beat.vec_z, in_beat.vec_y, in_beat.vec_x};
    st_nxt[0].axis  = {in_beat.axis_z, in_beat.axis_y, in_beat.axis_x};
    st_nxt[0].angle = in_beat.angle_turn;
    for (int i = 0; i < 3; i++) begin
      sqr = $signed(st_nxt[0].axis[i]) * $signed(st_nxt[0].axis[i]);
      st_nxt[0].prod[i] = PROD_W'($unsigned(sqr));
    end

    nsum = NORM_W'(st_r[0].prod[0]) + NORM_W'(st_r[0].prod[1]) + NORM_W'(st_r[0].prod[2]);
    st_nxt[1].m    = nsum;
    st_nxt[1].zero = (nsum == '0);

    // Normalize by pairs of bits so that one of the top two bits is set.
    st_nxt[2].jsh = '0;
    if (st_nxt[2].m[NORM_W-1 -: 16] == '0) begin
      st_nxt[2].m   = st_nxt[2].m << 16;
      st_nxt[2].jsh = J_W'(8);
    end
    if (st_nxt[2].m[NORM_W-1 -: 8] == '0) begin
      st_nxt[2].m   = st_nxt[2].m << 8;
      st_nxt[2].jsh = st_nxt[2].jsh + J_W'(4);
    end
    if (st_nxt[3].m[NORM_W-1 -: 4] == '0) begin
      st_nxt[3].m   = st_nxt[3].m << 4;
      st_nxt[3].jsh = st_nxt[3].jsh + J_W'(2);
    end
    if (st_nxt[3].m[NORM_W-1 -: 2] == '0) begin
      st_nxt[3].m   = st_nxt[3].m << 2;
      st_nxt[3].jsh = st_nxt[3].jsh + J_W'(1);
    end

    five_m = (NORM_W+2)'(st_r[3].m >> 2) * (NORM_W+2)'(5);
    st_nxt[4].y = Y0_BASE - RY_W'(five_m >> 2);

    for (int k = 0; k < RSQRT_STEPS; k++) begin
      b = NEWT0 + 3 * k;
      mul = (2*RY_W)'(st_r[b-1].y) * (2*RY_W)'(st_r[b-1].y);
      st_nxt[b].tmp = RY_W'(mul >> TRIG_Q);
      mul = (2*RY_W)'(st_r[b].m) * (2*RY_W)'(st_r[b].tmp);
      st_nxt[b+1].tmp = RY_W'(mul >> NORM_W);
      dval = (st_r[b+1].tmp < THREE) ? THREE - st_r[b+1].tmp : '0;
      mul = (2*RY_W)'(st_r[b+1].y) * (2*RY_W)'(dval);
      st_nxt[b+2].y = RY_W'(mul >> (TRIG_Q + 1));
    end

    for (int i = 0; i < 3; i++) begin
      ayp = $signed(st_r[UMUL-1].axis[i]) * $signed({1'b0, st_r[UMUL-1].y});
      st_nxt[UMUL].prod[i] = ayp;
    end

    esh = E_W'(COMP_BITS) - E_W'(st_r[UMUL].jsh);
    for (int i = 0; i < 3; i++) begin
      st_nxt[UMUL+1].prod[i] = $signed(st_r[UMUL].prod[i]) >>> esh;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    out_beat.vec   = st_r[NST-1].vec;
    out_beat.angle = st_r[NST-1].angle;
    out_beat.zero  = st_r[NST-1].zero;
    for (int i = 0; i < 3; i++) out_beat.unit[i] = st_r[NST-1].prod[i][UNIT_W-1:0];
  end

  assign out_valid = vld_r[NST-1];

endmodule

/* rtl/aavr_cordic.sv */
// ----------------------------------------------------------------------------
// Half-angle CORDIC
// Rotation-mode CORDIC, one iteration per stage, giving the cosine and sine
// of half the rotation angle in Q30.
// ----------------------------------------------------------------------------
module aavr_cordic import aavr_pkg::*; #(
  parameter int NSTG = CORDIC_STAGES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic       in_valid,
  input  axis_beat_t in_beat,
  output logic       out_valid,
  output trig_beat_t out_beat
);

  typedef struct packed {
    logic [2:0][COMP_BITS-1:0] vec;
    logic [2:0][UNIT_W-1:0]    unit;
    logic                      zero;
    logic                      flag;
    logic signed [TRIG_W-1:0]  x;
    logic signed [TRIG_W-1:0]  y;
    logic signed [TRIG_W-1:0]  z;
  } cor_st_t;

  cor_st_t         st_r   [NSTG];
  cor_st_t         st_nxt [NSTG];
  logic [NSTG-1:0] vld_r;

  function automatic cor_st_t cstep(input cor_st_t c, input int s);
    cor_st_t                  r;
    logic signed [TRIG_W-1:0] dx;
    logic signed [TRIG_W-1:0] dy;
    logic signed [TRIG_W-1:0] at;
    r  = c;
    dx = c.y >>> s;
    dy = c.x >>> s;
    at = $signed(atan_turn(s));
    if (!c.z[TRIG_W-1]) begin
      r.x = c.x - dx;
      r.y = c.y + dy;
      r.z = c.z - at;
    end else begin
      r.x = c.x + dx;
      r.y = c.y - dy;
      r.z = c.z + at;
    end
    return r;
  endfunction

  always_comb begin
    cor_st_t           seed;
    logic [TRIG_W-1:0] a32;
    a32       = TRIG_W'(in_beat.angle) << (TRIG_W - ANGLE_BITS);
    seed.vec  = in_beat.vec;
    seed.unit = in_beat.unit;
    seed.zero = in_beat.zero;
    // A half angle of a quarter turn or more is folded back by a quarter turn.
    seed.flag = a32[TRIG_W-1];
    seed.z    = $signed({2'b00, a32[TRIG_W-2:1]});
    seed.x    = INV_GAIN;
    seed.y    = '0;
    st_nxt[0] = cstep(seed, 0);
    for (int s = 1; s < NSTG; s++) st_nxt[s] = cstep(st_r[s-1], s);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    out_beat.vec   = st_r[NSTG-1].vec;
    out_beat.unit  = st_r[NSTG-1].unit;
    out_beat.zero  = st_r[NSTG-1].zero;
    out_beat.cos_v = st_r[NSTG-1].flag ? -st_r[NSTG-1].y : st_r[NSTG-1].x;
    out_beat.sin_v = st_r[NSTG-1].flag ? st_r[NSTG-1].x : st_r[NSTG-1].y;
  end

  assign out_valid = vld_r[NSTG-1];

endmodule

/* rtl/aavr_rotate.sv */
// ----------------------------------------------------------------------------
// Quaternion rotation
// Builds the Q22 quaternion, forms q*(0,v) and then (q*(0,v))*conj(q), and
// rounds and saturates the vector part.
// ----------------------------------------------------------------------------
module aavr_rotate import aavr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic       in_valid,
  input  trig_beat_t in_beat,
  output logic       out_valid,
  output out_beat_t  out_beat
);

  localparam int Q_W   = QUAT_Q + 2;
  localparam int HA_W  = Q_W + COMP_BITS;
  localparam int SA_W  = HA_W + 2;
  localparam int P_W   = SA_W - (QUAT_Q - P_GUARD);
  localparam int HB_W  = P_W + Q_W;
  localparam int SB_W  = HB_W + 2;
  localparam int C_W   = SB_W - (QUAT_Q + P_GUARD);
  localparam int PR_W  = 2 * TRIG_W;
  localparam int SH0   = TRIG_Q - QUAT_Q;
  localparam int SH1   = 2 * TRIG_Q - QUAT_Q;
  localparam int SH2   = QUAT_Q - P_GUARD;
  localparam int SH3   = QUAT_Q + P_GUARD;
  localparam int NSTG  = 6;

  localparam logic signed [TRIG_W:0] RND0 = (TRIG_W+1)'(1) << (SH0 - 1);
  localparam logic signed [PR_W-1:0] RND1 = PR_W'(1) << (SH1 - 1);
  localparam logic signed [SA_W-1:0] RND2 = SA_W'(1) << (SH2 - 1);
  localparam logic signed [SB_W-1:0] RND3 = SB_W'(1) << (SH3 - 1);
  localparam logic signed [C_W-1:0]  HI   = C_W'((2 ** (COMP_BITS - 1)) - 1);
  localparam logic signed [C_W-1:0]  LO   = -HI - C_W'(1);

  typedef struct packed {
    logic [2:0][COMP_BITS-1:0] vec;
    logic                      zero;
    logic [Q_W-1:0]            q0;
    logic [2:0][PR_W-1:0]      pr;
  } s0_t;

  typedef struct packed {
    logic [2:0][COMP_BITS-1:0] vec;
    logic                      zero;
    logic [3:0][Q_W-1:0]       q;
  } s1_t;

  typedef struct packed {
    logic [3:0][Q_W-1:0]  q;
    logic                 zero;
    logic [11:0][HA_W-1:0] hp;
  } s2_t;

  typedef struct packed {
    logic [3:0][Q_W-1:0] q;
    logic                zero;
    logic [3:0][P_W-1:0] p;
  } s3_t;

  typedef struct packed {
    logic                  zero;
    logic [11:0][HB_W-1:0] hp;
  } s4_t;

  s0_t             s0_r, s0_nxt;
  s1_t             s1_r, s1_nxt;
  s2_t             s2_r, s2_nxt;
  s3_t             s3_r, s3_nxt;
  s4_t             s4_r, s4_nxt;
  out_beat_t       out_r, out_nxt;
  logic [NSTG-1:0] vld_r;

  function automatic logic signed [HA_W-1:0] mul_qv(input logic [Q_W-1:0] a,
                                                    input logic [COMP_BITS-1:0] b);
    logic signed [HA_W-1:0] r;
    r = $signed(a) * $signed(b);
    return r;
  endfunction

  function automatic logic signed [HB_W-1:0] mul_pq(input logic [P_W-1:0] a,
                                                    input logic [Q_W-1:0] b);
    logic signed [HB_W-1:0] r;
    r = $signed(a) * $signed(b);
    return r;
  endfunction

  function automatic logic signed [SA_W-1:0] ext_a(input logic [HA_W-1:0] h);
    return SA_W'($signed(h));
  endfunction

  function automatic logic signed [SB_W-1:0] ext_b(input logic [HB_W-1:0] h);
    return SB_W'($signed(h));
  endfunction

  always_comb begin
    logic signed [TRIG_W:0] cext;
    logic signed [PR_W-1:0] prm;
    cext = $signed({in_beat.cos_v[TRIG_W-1], in_beat.cos_v}) + RND0;
    s0_nxt.vec  = in_beat.vec;
    s0_nxt.zero = in_beat.zero;
    s0_nxt.q0   = Q_W'(cext >>> SH0);
    for (int i = 0; i < 3; i++) begin
      prm = $signed(in_beat.sin_v) * $signed(in_beat.unit[i]);
      s0_nxt.pr[i] = prm;
    end
  end

  always_comb begin
    logic signed [PR_W-1:0] rq;
    s1_nxt.vec  = s0_r.vec;
    s1_nxt.zero = s0_r.zero;
    s1_nxt.q[0] = s0_r.q0;
    for (int i = 0; i < 3; i++) begin
      rq = $signed(s0_r.pr[i]) + RND1;
      s1_nxt.q[i+1] = Q_W'(rq >>> SH1);
    end
  end

  always_comb begin
    s2_nxt.q      = s1_r.q;
    s2_nxt.zero   = s1_r.zero;
    s2_nxt.hp[0]  = mul_qv(s1_r.q[1], s1_r.vec[0]);
    s2_nxt.hp[1]  = mul_qv(s1_r.q[2], s1_r.vec[1]);
    s2_nxt.hp[2]  = mul_qv(s1_r.q[3], s1_r.vec[2]);
    s2_nxt.hp[3]  = mul_qv(s1_r.q[0], s1_r.vec[0]);
    s2_nxt.hp[4]  = mul_qv(s1_r.q[2], s1_r.vec[2]);
    s2_nxt.hp[5]  = mul_qv(s1_r.q[3], s1_r.vec[1]);
    s2_nxt.hp[6]  = mul_qv(s1_r.q[0], s1_r.vec[1]);
    s2_nxt.hp[7]  = mul_qv(s1_r.q[1], s1_r.vec[2]);
    s2_nxt.hp[8]  = mul_qv(s1_r.q[3], s1_r.vec[0]);
    s2_nxt.hp[9]  = mul_qv(s1_r.q[0], s1_r.vec[2]);
    s2_nxt.hp[10] = mul_qv(s1_r.q[1], s1_r.vec[1]);
    s2_nxt.hp[11] = mul_qv(s1_r.q[2], s1_r.vec[0]);
  end

  always_comb begin
    logic signed [SA_W-1:0] ps [4];
    ps[0] = -ext_a(s2_r.hp[0]) - ext_a(s2_r.hp[1]) - ext_a(s2_r.hp[2]);
    ps[1] =  ext_a(s2_r.hp[3]) + ext_a(s2_r.hp[4]) - ext_a(s2_r.hp[5]);
    ps[2] =  ext_a(s2_r.hp[6]) - ext_a(s2_r.hp[7]) + ext_a(s2_r.hp[8]);
    ps[3] =  ext_a(s2_r.hp[9]) + ext_a(s2_r.hp[10]) - ext_a(s2_r.hp[11]);
    s3_nxt.q    = s2_r.q;
    s3_nxt.zero = s2_r.zero;
    for (int j = 0; j < 4; j++) s3_nxt.p[j] = P_W'((ps[j] + RND2) >>> SH2);
  end

  always_comb begin
    s4_nxt.zero   = s3_r.zero;
    s4_nxt.hp[0]  = mul_pq(s3_r.p[0], s3_r.q[1]);
    s4_nxt.hp[1]  = mul_pq(s3_r.p[1], s3_r.q[0]);
    s4_nxt.hp[2]  = mul_pq(s3_r.p[2], s3_r.q[3]);
    s4_nxt.hp[3]  = mul_pq(s3_r.p[3], s3_r.q[2]);
    s4_nxt.hp[4]  = mul_pq(s3_r.p[0], s3_r.q[2]);
    s4_nxt.hp[5]  = mul_pq(s3_r.p[1], s3_r.q[3]);
    s4_nxt.hp[6]  = mul_pq(s3_r.p[2], s3_r.q[0]);
    s4_nxt.hp[7]  = mul_pq(s3_r.p[3], s3_r.q[1]);
    s4_nxt.hp[8]  = mul_pq(s3_r.p[0], s3_r.q[3]);
    s4_nxt.hp[9]  = mul_pq(s3_r.p[1], s3_r.q[2]);
    s4_nxt.hp[10] = mul_pq(s3_r.p[2], s3_r.q[1]);
    s4_nxt.hp[11] = mul_pq(s3_r.p[3], s3_r.q[0]);
  end

  always_comb begin
    logic signed [SB_W-1:0] rs [3];
    logic signed [C_W-1:0]  c  [3];
    logic [2:0]             clip;
    rs[0] = -ext_b(s4_r.hp[0]) + ext_b(s4_r.hp[1]) - ext_b(s4_r.hp[2]) + ext_b(s4_r.hp[3]);
    rs[1] = -ext_b(s4_r.hp[4]) + ext_b(s4_r.hp[5]) + ext_b(s4_r.hp[6]) - ext_b(s4_r.hp[7]);
    rs[2] = -ext_b(s4_r.hp[8]) - ext_b(s4_r.hp[9]) + ext_b(s4_r.hp[10]) + ext_b(s4_r.hp[11]);
    for (int i = 0; i < 3; i++) begin
      c[i]    = C_W'((rs[i] + RND3) >>> SH3);
      clip[i] = 1'b0;
      if (c[i] > HI) begin
        c[i]    = HI;
        clip[i] = 1'b1;
      end else if (c[i] < LO) begin
        c[i]    = LO;
        clip[i] = 1'b1;
      end
    end
    if (s4_r.zero) begin
      out_nxt = '0;
      out_nxt.zero_axis = 1'b1;
    end else begin
      out_nxt.out_x     = COMP_BITS'(c[0]);
      out_nxt.out_y     = COMP_BITS'(c[1]);
      out_nxt.out_z     = COMP_BITS'(c[2]);
      out_nxt.zero_axis = 1'b0;
      out_nxt.saturated = |clip;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_r  <= s0_nxt;
      s1_r  <= s1_nxt;
      s2_r  <= s2_nxt;
      s3_r  <= s3_nxt;
      s4_r  <= s4_nxt;
      out_r <= out_nxt;
    end
  end

  assign out_beat  = out_r;
  assign out_valid = vld_r[NSTG-1];

endmodule

/* rtl/axis_angle_vector_rotate.sv */
// ----------------------------------------------------------------------------
// Axis-angle vector rotation
// Rotates a 3-D fixed-point vector about an arbitrary axis by a binary angle
// using a unit quaternion built from CORDIC sine and cosine.
// ----------------------------------------------------------------------------
// The block takes one beat per clock while it is not stalled and returns one
// beat per input beat, in order, after the axis normalizer with its five Newton
// steps, the CORDIC and the two quaternion products. The whole pipeline advances
// together; while an output beat waits under stall, every stage holds and
// in_stall is raised.
module axis_angle_vector_rotate import aavr_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_beat,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_beat
);

  logic       en;
  logic       rs_valid;
  axis_beat_t rs_beat;
  logic       cr_valid;
  trig_beat_t cr_beat;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  aavr_rsqrt u_rsqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_beat   (in_beat),
    .out_valid (rs_valid),
    .out_beat  (rs_beat)
  );

  aavr_cordic #(
    .NSTG (CORDIC_STAGES)
  ) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (rs_valid),
    .in_beat   (rs_beat),
    .out_valid (cr_valid),
    .out_beat  (cr_beat)
  );

  aavr_rotate u_rotate (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (cr_valid),
    .in_beat   (cr_beat),
    .out_valid (out_valid),
    .out_beat  (out_beat)
  );

endmodule
